// ===== design/lru_key_value_cache_macros.svh =====
// Assertion macros used by the checker of the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define LKV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lkv_pkg.sv =====
// Package with the shared constants, widths and types of the LRU key-value cache.
`timescale 1ns / 1ps

package lkv_pkg;

  // Field widths of the request, response and capacity register.
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // Default number of entries and the capacity after reset.
  localparam int DEFAULT_ENTRIES = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Value returned by a get that misses.
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  // Request type codes.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  // Width of an entry index or a rank for a given number of entries.
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Width of a count that can hold the number of entries itself.
  function automatic int cnt_w(input int n);
    return $clog2(n + 1);
  endfunction

  // Control from the sequencer to the entry store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } store_ctrl_t;

endpackage

// ===== design/lkv_if.sv =====
// Channel interfaces of the LRU key-value cache: request, response and capacity write.
`timescale 1ns / 1ps

// Request channel: one beat is a get or a set.
interface lkv_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic signed [lkv_pkg::KEY_W-1:0] key;
  logic signed [lkv_pkg::VAL_W-1:0] write_value;

  modport source (output valid, req_type, key, write_value, input ready);
  modport sink   (input valid, req_type, key, write_value, output ready);
endinterface

// Response channel: one beat per get.
interface lkv_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic signed [lkv_pkg::VAL_W-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

// Capacity register write channel.
interface lkv_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lkv_pkg::CAP_W-1:0]  capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

// ===== design/lkv_entry_store.sv =====
// Entry store of the LRU key-value cache: entry memory, valid bits and fill count.
`timescale 1ns / 1ps

module lkv_entry_store #(
  parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  lkv_pkg::store_ctrl_t                     ctrl,
  input  logic [lkv_pkg::idx_w(ENTRIES)-1:0]       rd_addr,
  input  logic [lkv_pkg::idx_w(ENTRIES)-1:0]       wr_addr,
  input  logic [lkv_pkg::KEY_W-1:0]                wr_key,
  input  logic [lkv_pkg::VAL_W-1:0]                wr_value,
  input  logic [lkv_pkg::idx_w(ENTRIES)-1:0]       wr_rank,
  output logic                                     rd_valid,
  output logic [lkv_pkg::KEY_W-1:0]                rd_key,
  output logic [lkv_pkg::VAL_W-1:0]                rd_value,
  output logic [lkv_pkg::idx_w(ENTRIES)-1:0]       rd_rank,
  output logic [lkv_pkg::cnt_w(ENTRIES)-1:0]       fill_count
);

  localparam int IdxW = lkv_pkg::idx_w(ENTRIES);
  localparam int CntW = lkv_pkg::cnt_w(ENTRIES);
  localparam int EntW = lkv_pkg::KEY_W + lkv_pkg::VAL_W + IdxW;

  logic [EntW-1:0]    mem [ENTRIES];
  logic [EntW-1:0]    rd_word;
  logic [ENTRIES-1:0] valid;

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= {wr_key, wr_value, wr_rank};
    end
    if (ctrl.rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_key   = rd_word[EntW-1 -: lkv_pkg::KEY_W];
  assign rd_value = rd_word[IdxW +: lkv_pkg::VAL_W];
  assign rd_rank  = rd_word[IdxW-1:0];

  // Valid bits and fill count; the valid bit is read alongside the memory word.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid   <= 1'b0;
      fill_count <= '0;
    end else begin
      if (ctrl.rd_en) begin
        rd_valid <= valid[rd_addr];
      end
      if (ctrl.set_valid) begin
        valid[wr_addr] <= 1'b1;
        fill_count     <= fill_count + CntW'(1);
      end else if (ctrl.clr_valid) begin
        valid[wr_addr] <= 1'b0;
        fill_count     <= fill_count - CntW'(1);
      end
    end
  end

endmodule

// ===== design/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: request sequencer, capacity register and response register.
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-set replacement.
// Channels: req takes get (req_type 0) and set (req_type 1) beats; rsp returns
// one beat per get with hit and read_value (-1 on a miss); cfg writes the
// capacity register, which is read clamped to the range 1..ENTRIES.
// Entries live in one memory with a registered read port, so every
// request walks it one entry per cycle. A get scans all entries, then
// moves to its response. A set scans once for the key, then walks the
// entries again to update ranks (and to evict on a full miss), then, on
// a miss, writes the new entry. The single memory port sets this pace.
// Reset clears the valid bits and the fill count at once and sets the
// capacity to 16; the cache is ready for requests in the first cycle after.
// The response sits in an output register: a new request is accepted while
// an earlier response waits. A get that finishes while the receiver still
// stalls holds in its response cycle until that register is free.
// Capacity must be written only while no request is in progress.
module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  lkv_cfg_if.sink    cfg,
  lkv_req_if.sink    req,
  lkv_rsp_if.source  rsp
);

  localparam int IdxW = lkv_pkg::idx_w(ENTRIES);
  localparam int CntW = lkv_pkg::cnt_w(ENTRIES);
  localparam int CapW = (CntW > lkv_pkg::CAP_W) ? CntW : lkv_pkg::CAP_W;
  localparam logic [CntW-1:0] LastCnt = CntW'(ENTRIES);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_INSERT = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0]                 state;
  logic [lkv_pkg::CAP_W-1:0]  capacity;

  // Captured request.
  logic                       req_type_q;
  logic [lkv_pkg::KEY_W-1:0]  key_q;
  logic [lkv_pkg::VAL_W-1:0]  value_q;

  // Walk counter and the index whose read data is arriving.
  logic [CntW-1:0]            cnt;
  logic                       chk;
  logic [IdxW-1:0]            chk_idx;

  // Scan results.
  logic                       found;
  logic [IdxW-1:0]            slot;
  logic [IdxW-1:0]            rank_hit;
  logic [lkv_pkg::VAL_W-1:0]  hit_value;
  logic                       evict;
  logic                       free_found;
  logic [IdxW-1:0]            free_idx;

  // Response register.
  logic                       rsp_valid_q;
  logic                       rsp_hit_q;
  logic [lkv_pkg::VAL_W-1:0]  rsp_value_q;

  // Store connections.
  lkv_pkg::store_ctrl_t       ctrl;
  logic [IdxW-1:0]            wr_addr;
  logic [lkv_pkg::KEY_W-1:0]  wr_key;
  logic [lkv_pkg::VAL_W-1:0]  wr_value;
  logic [IdxW-1:0]            wr_rank;
  logic                       rd_valid;
  logic [lkv_pkg::KEY_W-1:0]  rd_key;
  logic [lkv_pkg::VAL_W-1:0]  rd_value;
  logic [IdxW-1:0]            rd_rank;
  logic [CntW-1:0]            fill_count;

  // Decoded per-cycle conditions.
  logic                       walking;
  logic                       issue;
  logic                       pass_done;
  logic                       scan_match;
  logic                       evict_here;
  logic                       free_here;
  logic [CapW-1:0]            cap_wide;
  logic [CntW-1:0]            eff_cap;
  logic [CntW-1:0]            cap_m1;

  lkv_entry_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .rd_addr    (cnt[IdxW-1:0]),
    .wr_addr    (wr_addr),
    .wr_key     (wr_key),
    .wr_value   (wr_value),
    .wr_rank    (wr_rank),
    .rd_valid   (rd_valid),
    .rd_key     (rd_key),
    .rd_value   (rd_value),
    .rd_rank    (rd_rank),
    .fill_count (fill_count)
  );

  // Effective capacity: zero acts as one, anything above ENTRIES as ENTRIES.
  always_comb begin
    cap_wide = CapW'(capacity);
    if (cap_wide == '0) begin
      cap_wide = CapW'(1);
    end else if (cap_wide > CapW'(ENTRIES)) begin
      cap_wide = CapW'(ENTRIES);
    end
    eff_cap = cap_wide[CntW-1:0];
    cap_m1  = eff_cap - CntW'(1);
  end

  // Walk control and the per-entry decisions of the scan and update passes.
  always_comb begin
    walking    = (state == ST_SCAN) || (state == ST_UPDATE);
    issue      = walking && (cnt != LastCnt);
    pass_done  = walking && (cnt == LastCnt) && !chk;
    scan_match = (state == ST_SCAN) && chk && rd_valid && (rd_key == key_q) && !found;
    evict_here = (state == ST_UPDATE) && chk && !found && evict && rd_valid &&
                 (CntW'(rd_rank) >= cap_m1);
    free_here  = (state == ST_UPDATE) && chk && !found && (!rd_valid || evict_here);
  end

  // Store commands: read-modify-write of the entry one behind the read address, or the insert.
  always_comb begin
    ctrl           = '0;
    ctrl.rd_en     = issue;
    wr_addr        = chk_idx;
    wr_key         = rd_key;
    wr_value       = rd_value;
    wr_rank        = rd_rank + IdxW'(1);
    case (state)
      ST_UPDATE: begin
        if (chk && rd_valid) begin
          if (found) begin
            if (chk_idx == slot) begin
              ctrl.wr_en = 1'b1;
              wr_value   = value_q;
              wr_rank    = '0;
            end else if (rd_rank < rank_hit) begin
              ctrl.wr_en = 1'b1;
            end
          end else if (evict_here) begin
            ctrl.clr_valid = 1'b1;
          end else begin
            ctrl.wr_en = 1'b1;
          end
        end
      end
      ST_INSERT: begin
        ctrl.wr_en     = 1'b1;
        ctrl.set_valid = 1'b1;
        wr_addr        = free_idx;
        wr_key         = key_q;
        wr_value       = value_q;
        wr_rank        = '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, capacity register and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      capacity    <= lkv_pkg::CAP_RESET;
      cnt         <= '0;
      chk         <= 1'b0;
      found       <= 1'b0;
      evict       <= 1'b0;
      free_found  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.capacity;
      end
      if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end

      if (issue) begin
        cnt <= cnt + CntW'(1);
      end
      chk     <= issue;
      chk_idx <= cnt[IdxW-1:0];

      if (scan_match) begin
        found     <= 1'b1;
        slot      <= chk_idx;
        rank_hit  <= rd_rank;
        hit_value <= rd_value;
      end
      if (free_here && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            req_type_q <= req.req_type;
            key_q      <= req.key;
            value_q    <= req.write_value;
            cnt        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pass_done) begin
            cnt <= '0;
            if (req_type_q == lkv_pkg::REQ_GET) begin
              state <= ST_RESP;
            end else begin
              evict <= !found && (fill_count >= eff_cap);
              state <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          if (pass_done) begin
            state <= found ? ST_IDLE : ST_INSERT;
          end
        end
        ST_INSERT: begin
          state <= ST_IDLE;
        end
        ST_RESP: begin
          if (!rsp_valid_q || rsp.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_hit_q   <= found;
            rsp_value_q <= found ? hit_value : lkv_pkg::MISS_VALUE;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Port outputs.
  assign req.ready      = (state == ST_IDLE);
  assign cfg.ready      = 1'b1;
  assign rsp.valid      = rsp_valid_q;
  assign rsp.hit        = rsp_hit_q;
  assign rsp.read_value = rsp_value_q;

endmodule

// ===== design/lkv_checker.sv =====
// Port-level checker of the LRU key-value cache and its bind to the top level.
`timescale 1ns / 1ps
`include "lru_key_value_cache_macros.svh"

module lkv_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_hit,
  input logic [lkv_pkg::VAL_W-1:0]  rsp_read_value
);

  // A stalled response beat holds its payload.
  `LKV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value), "response changed while stalled")

  // A miss always reports the miss value.
  `LKV_ASSERT_SAME(a_miss_value, rsp_valid && !rsp_hit, rsp_read_value == lkv_pkg::MISS_VALUE, "miss without the miss value")

  // The cache works on one request at a time.
  `LKV_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request taken while busy")

  // A new response only comes out of a request in progress.
  `LKV_ASSERT_SAME(a_rsp_from_work, $rose(rsp_valid), !$past(req_ready), "response while idle")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_hit        (rsp.hit),
  .rsp_read_value (rsp.read_value)
);

// ===== tb/lru_key_value_cache_tb.sv =====
// Testbench for the LRU key-value cache: cache scoreboard, request and capacity drivers, checker.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

  localparam int SLOTS       = lkv_pkg::DEFAULT_ENTRIES;
  // A set may still be walking the entries after the last response: SETTLE covers it with margin.
  localparam int SETTLE      = 2 * SLOTS + 16;
  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 100;
  localparam int POOL_SIZE   = 24;

  // One expected get response.
  typedef struct packed {
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] data;
  } lookup_t;

  // Shadow copy of the cache contents plus the queue of expected get responses.
  class lru_scoreboard;
    logic [lkv_pkg::CAP_W-1:0] capacity_reg;
    logic [lkv_pkg::KEY_W-1:0] slot_key[SLOTS];
    logic [lkv_pkg::VAL_W-1:0] slot_data[SLOTS];
    bit                        slot_valid[SLOTS];
    int                        slot_rank[SLOTS];
    int                        fill;
    lookup_t                   pending_lookups[$];
    int                        mismatches;

    function new();
      capacity_reg = lkv_pkg::CAP_RESET;
      fill         = 0;
      mismatches   = 0;
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = 0;
      end
    endfunction

    function void set_capacity(logic [lkv_pkg::CAP_W-1:0] c);
      capacity_reg = c;
    endfunction

    function int outstanding();
      return pending_lookups.size();
    endfunction

    function int find_entry(logic [lkv_pkg::KEY_W-1:0] k);
      foreach (slot_valid[i])
        if (slot_valid[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    // Apply one accepted request beat to the shadow cache.
    function void note_request(logic rtype, logic [lkv_pkg::KEY_W-1:0] k,
                               logic [lkv_pkg::VAL_W-1:0] d);
      int      slot;
      int      cap;
      int      r;
      lookup_t exp_rsp;
      slot = find_entry(k);
      if (rtype == lkv_pkg::REQ_GET) begin
        exp_rsp.hit  = (slot >= 0);
        exp_rsp.data = (slot >= 0) ? slot_data[slot] : lkv_pkg::MISS_VALUE;
        pending_lookups.push_back(exp_rsp);
        return;
      end
      // Set hit: promote the entry and overwrite its data.
      if (slot >= 0) begin
        r = slot_rank[slot];
        foreach (slot_valid[i])
          if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
        slot_rank[slot] = 0;
        slot_data[slot] = d;
        return;
      end
      // Set miss: clamp the capacity, evict the oldest entries when full, then insert.
      cap = (capacity_reg == 0) ? 1 : ((capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg));
      if (fill >= cap) begin
        foreach (slot_valid[i]) begin
          if (slot_valid[i] && slot_rank[i] >= cap - 1) begin
            slot_valid[i] = 1'b0;
            fill--;
          end
        end
      end
      foreach (slot_valid[i])
        if (slot_valid[i]) slot_rank[i]++;
      foreach (slot_valid[i]) begin
        if (!slot_valid[i]) begin
          slot_valid[i] = 1'b1;
          slot_key[i]   = k;
          slot_data[i]  = d;
          slot_rank[i]  = 0;
          fill++;
          return;
        end
      end
    endfunction

    // Compare one accepted response beat with the oldest expectation.
    function void check_response(logic hit, logic [lkv_pkg::VAL_W-1:0] data);
      lookup_t exp_rsp;
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: response with none expected: hit=%b read_value=%h", $realtime,
                   hit, data);
        return;
      end
      exp_rsp = pending_lookups.pop_front();
      if (hit !== exp_rsp.hit || data !== exp_rsp.data) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected hit=%b read_value=%h, got hit=%b read_value=%h",
                   $realtime, exp_rsp.hit, exp_rsp.data, hit, data);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  lkv_cfg_if cfg_ch ();
  lkv_req_if req_ch ();
  lkv_rsp_if rsp_ch ();

  lru_key_value_cache u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lru_scoreboard             board;
  bit                        send_busy = 1'b1;
  bit                        recv_busy = 1'b1;
  int                        idle_cycles = 0;
  logic [lkv_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request beat after a random gap and wait until it is taken.
  task automatic send_request(input logic rtype, input logic [lkv_pkg::KEY_W-1:0] k,
                              input logic [lkv_pkg::VAL_W-1:0] d);
    int gap;
    gap = send_busy ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rtype;
    req_ch.key         <= k;
    req_ch.write_value <= d;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(rtype, k, d);
  endtask

  // Stop sending, wait for every expected response, then let a trailing set finish.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the capacity register while the cache is idle.
  task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] c);
    drain_responses();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    board.set_capacity(c);
  endtask

  // Response side: random stalls on ready, every accepted beat is checked.
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = recv_busy ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      board.check_response(rsp_ch.hit, rsp_ch.read_value);
    end
  end

  // Stimulus: directed cases, then random phases under several capacities.
  initial begin
    logic [lkv_pkg::CAP_W-1:0] cap_plan[PHASES];
    logic [lkv_pkg::KEY_W-1:0] k;
    int                        span;
    int                        eff_cap;

    board = new();
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= lkv_pkg::REQ_GET;
    req_ch.key         <= '0;
    req_ch.write_value <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.capacity    <= lkv_pkg::CAP_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty cache, then the key and value extremes, a miss and an update.
    send_request(lkv_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(lkv_pkg::REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lkv_pkg::REQ_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lkv_pkg::REQ_SET, 32'h0000_0000, 32'h0000_0000);
    send_request(lkv_pkg::REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lkv_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(lkv_pkg::REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(lkv_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(lkv_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lkv_pkg::REQ_GET, 32'h0000_0001, 32'h0000_0000);
    send_request(lkv_pkg::REQ_SET, 32'h8000_0000, 32'h1234_5678);
    send_request(lkv_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);

    // Capacity lowered below the fill count: the next missing set trims the old entries.
    write_capacity(5'd2);
    send_request(lkv_pkg::REQ_SET, 32'h0000_0005, 32'hA5A5_A5A5);
    send_request(lkv_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(lkv_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lkv_pkg::REQ_GET, 32'h0000_0005, 32'h0000_0000);

    // Capacity zero behaves as one.
    write_capacity(5'd0);
    send_request(lkv_pkg::REQ_SET, 32'h0000_0006, 32'h5A5A_5A5A);
    send_request(lkv_pkg::REQ_GET, 32'h0000_0005, 32'h0000_0000);
    send_request(lkv_pkg::REQ_GET, 32'h0000_0006, 32'h0000_0000);
    send_request(lkv_pkg::REQ_SET, 32'h0000_0006, 32'hDEAD_BEEF);
    send_request(lkv_pkg::REQ_GET, 32'h0000_0006, 32'h0000_0000);

    // Capacity above the entry count behaves as the entry count.
    write_capacity(5'd31);
    send_request(lkv_pkg::REQ_SET, 32'h0000_0007, 32'h0F0F_0F0F);
    send_request(lkv_pkg::REQ_GET, 32'h0000_0006, 32'h0000_0000);
    send_request(lkv_pkg::REQ_GET, 32'h0000_0007, 32'h0000_0000);

    // Key pool: the extremes plus random keys, so sets and gets collide often.
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;

    cap_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd8, 5'd16, 5'd2};
    cap_plan[5] = lkv_pkg::CAP_W'($urandom_range(1, SLOTS));

    for (int phase = 0; phase < PHASES; phase++) begin
      write_capacity(cap_plan[phase]);
      send_busy = (phase % 3 != 0);
      recv_busy = (phase % 4 != 1);
      eff_cap = (cap_plan[phase] == 0) ? 1 :
                ((cap_plan[phase] > SLOTS) ? SLOTS : int'(cap_plan[phase]));
      span = (eff_cap + 5 < POOL_SIZE) ? eff_cap + 5 : POOL_SIZE;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        k = ($urandom_range(0, 7) == 0) ? $urandom : key_pool[$urandom_range(0, span - 1)];
        send_request($urandom_range(0, 1) ? lkv_pkg::REQ_SET : lkv_pkg::REQ_GET, k, $urandom);
      end
    end

    drain_responses();
    if (board.mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
